[src/cdf_pkg.sv]
// ----------------------------------------------------------------------------
// CDF package
// Types, codes and the CRC-16 byte update shared by the deframer modules.
// ----------------------------------------------------------------------------
package cdf_pkg;

  localparam logic [7:0] StartByte = 8'h02;
  localparam logic [7:0] EndByte   = 8'h03;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindGood    = 2'd1;
  localparam logic [1:0] KindCrcErr  = 2'd2;
  localparam logic [1:0] KindEndErr  = 2'd3;

  // Configuration register indexes.
  localparam logic CfgPolynomial = 1'b0;
  localparam logic CfgInitial    = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] frame_length;
    logic [7:0] data;
  } result_t;

  // One byte of an MSB-first CRC-16, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/crc_checked_packet_deframer_top.sv]
// ----------------------------------------------------------------------------
// CRC-checked packet deframer
// Start byte, length, payload, big-endian CRC-16 and end byte deframer.
// ----------------------------------------------------------------------------
// The block takes one received byte per transfer and can take a byte every
// cycle unless its skid stage is full: the frame state and the byte-wide CRC
// update are worked out in the cycle a byte is accepted, and any result lands
// in an output register backed by a one-entry skid stage. Each payload byte is
// passed out with kind 0; after the end byte one status result gives good, CRC
// mismatch or bad end byte along with the payload length. Bytes outside a frame
// are dropped until the start byte shows up. The user must write the polynomial
// and initial value through the cfg port while idle, which the block does not
// enforce; the initial value is taken when the length byte arrives.
module crc_checked_packet_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Received bytes.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data, [15:8] frame_length
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhLen   = 3'd1;
  localparam logic [2:0] PhPay   = 3'd2;
  localparam logic [2:0] PhCrcHi = 3'd3;
  localparam logic [2:0] PhCrcLo = 3'd4;
  localparam logic [2:0] PhEnd   = 3'd5;

  logic [15:0] poly_q, init_q;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rx_crc_q, rx_crc_d;

  logic             accept;
  logic             push;
  cdf_pkg::result_t res;
  cdf_pkg::result_t out_res;
  logic [7:0]       b;

  assign b      = s_axis_tdata;
  assign accept = s_axis_tvalid & s_axis_tready;

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    len_d    = len_q;
    crc_d    = crc_q;
    rx_crc_d = rx_crc_q;
    push     = 1'b0;
    res      = '0;
    unique case (phase_q)
      PhLen: begin
        len_d   = b;
        left_d  = b;
        crc_d   = init_q;
        phase_d = (b == 8'd0) ? PhCrcHi : PhPay;
      end
      PhPay: begin
        crc_d    = cdf_pkg::crc16_byte(crc_q, b, poly_q);
        left_d   = left_q - 8'd1;
        if (left_q == 8'd1) begin
          phase_d = PhCrcHi;
        end
        push     = 1'b1;
        res.kind = cdf_pkg::KindPayload;
        res.data = b;
      end
      PhCrcHi: begin
        rx_crc_d = {b, 8'h00};
        phase_d  = PhCrcLo;
      end
      PhCrcLo: begin
        rx_crc_d = {rx_crc_q[15:8], b};
        phase_d  = PhEnd;
      end
      PhEnd: begin
        push = 1'b1;
        if (b != cdf_pkg::EndByte) begin
          res.kind = cdf_pkg::KindEndErr;
        end else if (crc_q == rx_crc_q) begin
          res.kind = cdf_pkg::KindGood;
        end else begin
          res.kind = cdf_pkg::KindCrcErr;
        end
        res.frame_length = len_q;
        phase_d          = PhHunt;
      end
      default: begin
        // Hunting, including the unused phase codes.
        phase_d = (b == cdf_pkg::StartByte) ? PhLen : PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q   <= 16'h1021;
      init_q   <= 16'h0000;
      phase_q  <= PhHunt;
      left_q   <= 8'd0;
      len_q    <= 8'd0;
      crc_q    <= 16'h0000;
      rx_crc_q <= 16'h0000;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          cdf_pkg::CfgPolynomial: poly_q <= cfg_data_i;
          cdf_pkg::CfgInitial:    init_q <= cfg_data_i;
          default:                poly_q <= poly_q;
        endcase
      end
      if (accept) begin
        phase_q  <= phase_d;
        left_q   <= left_d;
        len_q    <= len_d;
        crc_q    <= crc_d;
        rx_crc_q <= rx_crc_d;
      end
    end
  end

  cdf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept & push),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .pop_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {out_res.frame_length, out_res.data};
  assign m_axis_tuser = out_res.kind;

endmodule

[src/cdf_out_buf.sv]
// ----------------------------------------------------------------------------
// CDF output buffer
// Output register with a skid stage, so a new result can be taken while the
// previous one still waits for the downstream side.
// ----------------------------------------------------------------------------
module cdf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cdf_pkg::result_t  push_data_i,
  output logic              ready_o,
  output logic              valid_o,
  output cdf_pkg::result_t  data_o,
  input  logic              pop_ready_i
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  cdf_pkg::result_t out_q, out_d;
  cdf_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop     = out_valid_q & pop_ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q & ~pop;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      // Input side is stalled while the skid stage is full.
      if (pop) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

[sim/crc_checked_packet_deframer_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked packet deframer testbench
// Feeds framed byte streams, noise and broken frames into the deframer under
// random source gaps and sink stalls, and checks every payload byte and frame
// status against a cycle-free model of the framing and CRC-16 logic.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer_top_test;

  localparam int WatchdogLimit = 2000;
  localparam int LongHoldCycles = 300;
  localparam int BytesPerPhase = 70;

  typedef enum logic [2:0] {
    RxHunt, RxLength, RxPayload, RxCrcHigh, RxCrcLow, RxEndByte
  } rx_phase_e;

  typedef enum logic [1:0] {CloseClean, CloseCrcBad, CloseEndBad} frame_close_e;

  typedef logic [7:0] octet_q_t[$];

  class frame_scoreboard;
    logic [15:0]      poly;
    logic [15:0]      init;
    rx_phase_e        phase;
    logic [7:0]       left;
    logic [7:0]       frame_len;
    logic [15:0]      crc_acc;
    logic [15:0]      crc_rx;
    cdf_pkg::result_t pending_results[$];
    int               mismatches;

    function new();
      poly       = 16'h1021;
      init       = 16'h0000;
      phase      = RxHunt;
      left       = '0;
      frame_len  = '0;
      crc_acc    = '0;
      crc_rx     = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] value);
      if (idx == cdf_pkg::CfgPolynomial) begin
        poly = value;
      end else begin
        init = value;
      end
    endfunction

    function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        r = r[15] ? ({r[14:0], 1'b0} ^ poly) : {r[14:0], 1'b0};
      end
      return r;
    endfunction

    function logic [15:0] payload_crc(octet_q_t payload);
      logic [15:0] r;
      r = init;
      foreach (payload[i]) r = crc_update(r, payload[i]);
      return r;
    endfunction

    // Returns 0 only for a byte dropped while hunting for a start byte.
    function bit note_byte(logic [7:0] b);
      cdf_pkg::result_t r;
      r = '0;
      case (phase)
        RxLength: begin
          frame_len = b;
          left      = b;
          crc_acc   = init;
          phase     = (b == 8'd0) ? RxCrcHigh : RxPayload;
        end
        RxPayload: begin
          crc_acc = crc_update(crc_acc, b);
          left    = left - 8'd1;
          if (left == 8'd0) phase = RxCrcHigh;
          r.kind = cdf_pkg::KindPayload;
          r.data = b;
          pending_results.push_back(r);
        end
        RxCrcHigh: begin
          crc_rx = {b, 8'h00};
          phase  = RxCrcLow;
        end
        RxCrcLow: begin
          crc_rx[7:0] = b;
          phase       = RxEndByte;
        end
        RxEndByte: begin
          // A bad end byte wins over the CRC and is never taken as a start.
          if (b != cdf_pkg::EndByte) begin
            r.kind = cdf_pkg::KindEndErr;
          end else if (crc_acc == crc_rx) begin
            r.kind = cdf_pkg::KindGood;
          end else begin
            r.kind = cdf_pkg::KindCrcErr;
          end
          r.frame_length = frame_len;
          pending_results.push_back(r);
          phase = RxHunt;
        end
        default: begin
          phase = (b == cdf_pkg::StartByte) ? RxLength : RxHunt;
          return b == cdf_pkg::StartByte;
        end
      endcase
      return 1'b1;
    endfunction

    function void check_result(cdf_pkg::result_t got);
      cdf_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d data %h length %0d", $time,
                 got.kind, got.data, got.frame_length);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        mismatches++;
      end
      if (got.data != want.data) begin
        $display("%0t: data expected %h actual %h", $time, want.data, got.data);
        mismatches++;
      end
      if (got.frame_length != want.frame_length) begin
        $display("%0t: frame_length expected %0d actual %0d", $time,
                 want.frame_length, got.frame_length);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // [7:0] data, [15:8] frame_length
  logic [1:0]  m_axis_tuser;    // [1:0] kind

  frame_scoreboard frames = new();
  bit src_gaps;
  bit sink_stalls;
  bit hold_off;
  int bytes_taken;
  int quiet_cycles = 0;

  crc_checked_packet_deframer_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      frames.check_result({m_axis_tuser, m_axis_tdata[15:8], m_axis_tdata[7:0]});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
        $display("crc_checked_packet_deframer_top_test: FAIL");
        $finish;
      end
    end
  end

  // Result sink: random stalls, and one long hold-off that backs up the input.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (frames.note_byte(b)) bytes_taken++;
  endtask

  task automatic send_frame(input octet_q_t payload, input frame_close_e how,
                            input logic [7:0] bad_end);
    logic [15:0] crc;
    crc = frames.payload_crc(payload);
    if (how == CloseCrcBad) crc ^= 16'($urandom_range(1, 65535));
    send_byte(cdf_pkg::StartByte);
    send_byte(8'(payload.size()));
    foreach (payload[i]) send_byte(payload[i]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    send_byte((how == CloseEndBad) ? bad_end : cdf_pkg::EndByte);
  endtask

  function automatic octet_q_t random_payload(int n);
    octet_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Mostly short frames; a length of 255 only now and then.
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 4);
    if (r < 90) return $urandom_range(5, 20);
    if (r < 98) return $urandom_range(21, 64);
    return 255;
  endfunction

  task automatic random_traffic();
    int sel;
    int n;
    logic [7:0] bad_end;
    frame_close_e how;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      n = $urandom_range(0, 9);
      how = (n < 6) ? CloseClean : (n < 8) ? CloseCrcBad : CloseEndBad;
      bad_end = 8'($urandom_range(0, 255));
      if (bad_end == cdf_pkg::EndByte || $urandom_range(0, 3) == 0) begin
        bad_end = cdf_pkg::StartByte;
      end
      send_frame(random_payload(pick_length()), how, bad_end);
    end else if (sel < 85) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      // Truncated frame: whatever follows is read as the rest of it.
      n = $urandom_range(1, 20);
      send_byte(cdf_pkg::StartByte);
      send_byte(8'(n));
      repeat ($urandom_range(0, n)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Complete any open frame, then wait until every result is back and the
  // output stage has had time to empty.
  task automatic drain();
    while (frames.phase != RxHunt) send_byte(8'($urandom_range(0, 255)));
    s_axis_tvalid <= 1'b0;
    while (frames.pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    frames.write_reg(idx, value);
  endtask

  initial begin
    octet_q_t pl;
    logic [15:0] poly;
    logic [15:0] init;
    int phase_start;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= cdf_pkg::CfgPolynomial;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    hold_off    = 1'b0;
    bytes_taken = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset register values.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cdf_pkg::EndByte);
    pl = {};
    send_frame(pl, CloseClean, cdf_pkg::EndByte);
    pl = {8'hFF};
    send_frame(pl, CloseClean, cdf_pkg::EndByte);
    pl = {8'h00, 8'h80};
    send_frame(pl, CloseCrcBad, cdf_pkg::EndByte);
    // A start byte in the end position is a bad end, not a new frame.
    pl = {};
    send_frame(pl, CloseEndBad, cdf_pkg::StartByte);
    send_byte(8'h00);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin poly = 16'h1021; init = 16'h0000; end
        1: begin poly = 16'h8005; init = 16'hFFFF; end
        2: begin poly = 16'hFFFF; init = 16'h0000; end
        3: begin poly = 16'h0000; init = 16'hFFFF; end
        default: begin
          poly = 16'($urandom_range(0, 65535));
          init = 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(cdf_pkg::CfgPolynomial, poly);
      write_reg(cdf_pkg::CfgInitial, init);
      src_gaps    = (ph % 3 != 2) && (ph < 7);
      sink_stalls = (ph % 3 != 1) && (ph < 7);
      if (ph == 2) begin
        hold_off = 1'b1;
        send_frame(random_payload(255), CloseClean, cdf_pkg::EndByte);
      end
      phase_start = bytes_taken;
      while (bytes_taken - phase_start < BytesPerPhase) random_traffic();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (frames.mismatches == 0 && frames.pending_results.size() == 0) begin
      $display("crc_checked_packet_deframer_top_test: PASS");
    end else begin
      $display("crc_checked_packet_deframer_top_test: FAIL");
    end
    $finish;
  end

endmodule

[crc_checked_packet_deframer_top.f]
src/cdf_pkg.sv
src/cdf_out_buf.sv
src/crc_checked_packet_deframer_top.sv
sim/crc_checked_packet_deframer_top_test.sv
